// ----- hw/rtl/gwck_pkg.sv -----
// Shared types, constants and helpers for the grid window color key mask.
`timescale 1ns / 1ps
package gwck_pkg;

  localparam int IMG_W  = 13;
  localparam int BLK_W  = 12;
  localparam int TOL_W  = 8;
  localparam int CH_W   = 8;
  localparam int OFF_W  = 12;
  localparam int GCOL_W = 5;
  localparam int GROW_W = 4;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int GRID_COLUMNS_DEF = 11;
  localparam int GRID_ROWS_DEF    = 6;
  localparam int SEPARATOR_DEF    = 4;
  localparam int COORD_BITS_DEF   = 12;

  localparam logic [CH_W-1:0] CH_MAX      = 8'hFF;
  localparam logic [CH_W-1:0] MINOR_LIMIT = 8'd110;

  localparam logic [IMG_W-1:0] IMAGE_WIDTH_RST  = 13'd1024;
  localparam logic [IMG_W-1:0] IMAGE_HEIGHT_RST = 13'd768;
  localparam logic [BLK_W-1:0] TILE_WIDTH_RST   = 12'd89;
  localparam logic [BLK_W-1:0] TILE_HEIGHT_RST  = 12'd124;
  localparam logic [BLK_W-1:0] HALF_WIN_W_RST   = 12'd19;
  localparam logic [BLK_W-1:0] HALF_WIN_H_RST   = 12'd22;
  localparam logic [TOL_W-1:0] STRONG_TOL_RST   = 8'd20;
  localparam logic [TOL_W-1:0] GREEN_TOL_RST    = 8'd80;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH        = 3'd0,
    REG_IMAGE_HEIGHT       = 3'd1,
    REG_TILE_WIDTH         = 3'd2,
    REG_TILE_HEIGHT        = 3'd3,
    REG_HALF_WINDOW_WIDTH  = 3'd4,
    REG_HALF_WINDOW_HEIGHT = 3'd5,
    REG_STRONG_TOL         = 3'd6,
    REG_GREEN_STRONG_TOL   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [IMG_W-1:0] image_width;
    logic [IMG_W-1:0] image_height;
    logic [BLK_W-1:0] tile_width;
    logic [BLK_W-1:0] tile_height;
    logic [BLK_W-1:0] half_window_width;
    logic [BLK_W-1:0] half_window_height;
    logic [TOL_W-1:0] strong_tolerance;
    logic [TOL_W-1:0] green_strong_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [GCOL_W-1:0] grid_column;
    logic [OFF_W-1:0]  column_offset;
    logic [GROW_W-1:0] grid_row;
    logic [OFF_W-1:0]  row_offset;
    logic              frame_end;
  } pos_t;

  function automatic logic strong_colour(input logic [CH_W-1:0] r,
                                         input logic [CH_W-1:0] g,
                                         input logic [CH_W-1:0] b,
                                         input logic [TOL_W-1:0] tol,
                                         input logic [TOL_W-1:0] gtol);
    logic rs, gs, bs, rm, gm, bm;
    rs = (CH_MAX - r) <= tol;
    gs = (CH_MAX - g) <= gtol;
    bs = (CH_MAX - b) <= tol;
    rm = r <= MINOR_LIMIT;
    gm = g <= MINOR_LIMIT;
    bm = b <= MINOR_LIMIT;
    return (rs && gm && bm) || (rm && gs && bm) || (rm && gm && bs);
  endfunction

endpackage

// ----- hw/rtl/gwck_regs.sv -----
// APB configuration registers.
`timescale 1ns / 1ps
module gwck_regs import gwck_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width            <= IMAGE_WIDTH_RST;
      cfg_r.image_height           <= IMAGE_HEIGHT_RST;
      cfg_r.tile_width             <= TILE_WIDTH_RST;
      cfg_r.tile_height            <= TILE_HEIGHT_RST;
      cfg_r.half_window_width      <= HALF_WIN_W_RST;
      cfg_r.half_window_height     <= HALF_WIN_H_RST;
      cfg_r.strong_tolerance       <= STRONG_TOL_RST;
      cfg_r.green_strong_tolerance <= GREEN_TOL_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_IMAGE_WIDTH:        cfg_r.image_width            <= pwdata[IMG_W-1:0];
        REG_IMAGE_HEIGHT:       cfg_r.image_height           <= pwdata[IMG_W-1:0];
        REG_TILE_WIDTH:         cfg_r.tile_width             <= pwdata[BLK_W-1:0];
        REG_TILE_HEIGHT:        cfg_r.tile_height            <= pwdata[BLK_W-1:0];
        REG_HALF_WINDOW_WIDTH:  cfg_r.half_window_width      <= pwdata[BLK_W-1:0];
        REG_HALF_WINDOW_HEIGHT: cfg_r.half_window_height     <= pwdata[BLK_W-1:0];
        REG_STRONG_TOL:         cfg_r.strong_tolerance       <= pwdata[TOL_W-1:0];
        REG_GREEN_STRONG_TOL:   cfg_r.green_strong_tolerance <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_IMAGE_WIDTH:        prdata = DATA_W'(cfg_r.image_width);
      REG_IMAGE_HEIGHT:       prdata = DATA_W'(cfg_r.image_height);
      REG_TILE_WIDTH:         prdata = DATA_W'(cfg_r.tile_width);
      REG_TILE_HEIGHT:        prdata = DATA_W'(cfg_r.tile_height);
      REG_HALF_WINDOW_WIDTH:  prdata = DATA_W'(cfg_r.half_window_width);
      REG_HALF_WINDOW_HEIGHT: prdata = DATA_W'(cfg_r.half_window_height);
      REG_STRONG_TOL:         prdata = DATA_W'(cfg_r.strong_tolerance);
      REG_GREEN_STRONG_TOL:   prdata = DATA_W'(cfg_r.green_strong_tolerance);
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/gwck_cnt.sv -----
// Raster position and grid block counters.
`timescale 1ns / 1ps
module gwck_cnt import gwck_pkg::*; #(
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF,
  parameter int SEPARATOR    = SEPARATOR_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  cfg_t cfg,
  output pos_t pos
);

  localparam int CMP_W = (COORD_BITS + 1 > IMG_W) ? COORD_BITS + 1 : IMG_W;

  logic [COORD_BITS-1:0] pixel_column_r, pixel_column_nxt;
  logic [COORD_BITS-1:0] pixel_row_r, pixel_row_nxt;
  logic [GCOL_W-1:0]     grid_column_r, grid_column_nxt;
  logic [OFF_W-1:0]      column_offset_r, column_offset_nxt;
  logic [GROW_W-1:0]     grid_row_r, grid_row_nxt;
  logic [OFF_W-1:0]      row_offset_r, row_offset_nxt;

  logic [BLK_W:0] pitch_x, pitch_y;
  logic [BLK_W:0] col_off_inc, row_off_inc;
  logic [CMP_W-1:0] col_inc, row_inc;
  logic row_end, frame_end;

  assign pitch_x     = {1'b0, cfg.tile_width} + (BLK_W+1)'(SEPARATOR);
  assign pitch_y     = {1'b0, cfg.tile_height} + (BLK_W+1)'(SEPARATOR);
  assign col_off_inc = {1'b0, column_offset_r} + (BLK_W+1)'(1);
  assign row_off_inc = {1'b0, row_offset_r} + (BLK_W+1)'(1);
  assign col_inc     = CMP_W'(pixel_column_r) + CMP_W'(1);
  assign row_inc     = CMP_W'(pixel_row_r) + CMP_W'(1);
  assign row_end     = col_inc >= CMP_W'(cfg.image_width);
  assign frame_end   = row_end && (row_inc >= CMP_W'(cfg.image_height));

  always_comb begin
    pixel_column_nxt  = pixel_column_r;
    pixel_row_nxt     = pixel_row_r;
    grid_column_nxt   = grid_column_r;
    column_offset_nxt = column_offset_r;
    grid_row_nxt      = grid_row_r;
    row_offset_nxt    = row_offset_r;
    if (row_end) begin
      pixel_column_nxt  = '0;
      grid_column_nxt   = '0;
      column_offset_nxt = '0;
      if (frame_end) begin
        pixel_row_nxt  = '0;
        grid_row_nxt   = '0;
        row_offset_nxt = '0;
      end else begin
        pixel_row_nxt = row_inc[COORD_BITS-1:0];
        if (grid_row_r < GROW_W'(GRID_ROWS) && row_off_inc >= pitch_y) begin
          grid_row_nxt   = grid_row_r + GROW_W'(1);
          row_offset_nxt = '0;
        end else begin
          row_offset_nxt = row_off_inc[OFF_W-1:0];
        end
      end
    end else begin
      pixel_column_nxt = col_inc[COORD_BITS-1:0];
      if (grid_column_r < GCOL_W'(GRID_COLUMNS) && col_off_inc >= pitch_x) begin
        grid_column_nxt   = grid_column_r + GCOL_W'(1);
        column_offset_nxt = '0;
      end else begin
        column_offset_nxt = col_off_inc[OFF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_column_r  <= '0;
      pixel_row_r     <= '0;
      grid_column_r   <= '0;
      column_offset_r <= '0;
      grid_row_r      <= '0;
      row_offset_r    <= '0;
    end else if (step) begin
      pixel_column_r  <= pixel_column_nxt;
      pixel_row_r     <= pixel_row_nxt;
      grid_column_r   <= grid_column_nxt;
      column_offset_r <= column_offset_nxt;
      grid_row_r      <= grid_row_nxt;
      row_offset_r    <= row_offset_nxt;
    end
  end

  assign pos.grid_column   = grid_column_r;
  assign pos.column_offset = column_offset_r;
  assign pos.grid_row      = grid_row_r;
  assign pos.row_offset    = row_offset_r;
  assign pos.frame_end     = frame_end;

endmodule

// ----- hw/rtl/gwck_axis.sv -----
// Block coverage and window test along one axis.
`timescale 1ns / 1ps
module gwck_axis import gwck_pkg::*; #(
  parameter int IDX_W     = GCOL_W,
  parameter int COUNT     = GRID_COLUMNS_DEF,
  parameter int SEPARATOR = SEPARATOR_DEF,
  parameter bit ROW_SHIFT = 1'b0
) (
  input  logic [IDX_W-1:0] idx,
  input  logic [OFF_W-1:0] off,
  input  logic [BLK_W-1:0] block,
  input  logic [BLK_W-1:0] half,
  output logic             covered,
  output logic             ok
);

  localparam int WW = BLK_W + 3;

  logic [BLK_W-1:0] hb;
  logic [BLK_W:0]   pitch;
  logic [IDX_W-1:0] shift_cur, shift_prev;
  logic in_cur, in_prev, win_cur, win_prev;

  function automatic logic in_win(input logic [WW-1:0] p, input logic [WW-1:0] c,
                                  input logic [WW-1:0] h);
    return (p + h >= c) && (p <= c + h);
  endfunction

  assign hb         = block >> 1;
  assign pitch      = {1'b0, block} + (BLK_W+1)'(SEPARATOR);
  assign shift_cur  = ROW_SHIFT ? idx : '0;
  assign shift_prev = ROW_SHIFT ? idx - IDX_W'(1) : '0;

  assign in_cur  = idx < IDX_W'(COUNT);
  assign in_prev = (off == '0) && (idx != '0) && (idx <= IDX_W'(COUNT));

  assign win_cur  = in_win(WW'(off), WW'(hb) + WW'(shift_cur), WW'(half));
  assign win_prev = in_win(WW'(pitch), WW'(hb) + WW'(shift_prev), WW'(half));

  assign covered = in_cur || in_prev;
  assign ok      = !(in_cur && !win_cur) && !(in_prev && !win_prev);

endmodule

// ----- hw/rtl/grid_window_color_key_mask.sv -----
// Grid window color key mask top level.
// The output is registered: a request accepted at a clock edge shows on the output in the next cycle.
// Throughput: one pixel per cycle; in_ready stays high while the output
// register is empty or being drained in the same cycle.
// Reset (rst_n, synchronous): registers return to defaults, counters to the
// first pixel of a frame, output register empties.
`timescale 1ns / 1ps
module grid_window_color_key_mask import gwck_pkg::*; #(
  parameter int GRID_COLUMNS = GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = GRID_ROWS_DEF,
  parameter int SEPARATOR    = SEPARATOR_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   in_red,
  input  logic [CH_W-1:0]   in_green,
  input  logic [CH_W-1:0]   in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_red,
  output logic [CH_W-1:0]   out_green,
  output logic [CH_W-1:0]   out_blue,
  output logic              out_blackened,
  output logic              out_frame_end
);

  cfg_t cfg;
  pos_t pos;
  logic accept, xcov, ycov, xok, yok, key_hit, black;
  logic out_valid_r;
  logic [CH_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic out_blackened_r, out_frame_end_r;

  gwck_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gwck_cnt #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .SEPARATOR    (SEPARATOR),
    .COORD_BITS   (COORD_BITS)
  ) u_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .cfg   (cfg),
    .pos   (pos)
  );

  gwck_axis #(
    .IDX_W     (GCOL_W),
    .COUNT     (GRID_COLUMNS),
    .SEPARATOR (SEPARATOR),
    .ROW_SHIFT (1'b0)
  ) u_axis_x (
    .idx     (pos.grid_column),
    .off     (pos.column_offset),
    .block   (cfg.tile_width),
    .half    (cfg.half_window_width),
    .covered (xcov),
    .ok      (xok)
  );

  gwck_axis #(
    .IDX_W     (GROW_W),
    .COUNT     (GRID_ROWS),
    .SEPARATOR (SEPARATOR),
    .ROW_SHIFT (1'b1)
  ) u_axis_y (
    .idx     (pos.grid_row),
    .off     (pos.row_offset),
    .block   (cfg.tile_height),
    .half    (cfg.half_window_height),
    .covered (ycov),
    .ok      (yok)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign key_hit  = strong_colour(in_red, in_green, in_blue,
                                  cfg.strong_tolerance, cfg.green_strong_tolerance);
  assign black    = xcov && ycov && (!(xok && yok) || key_hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_red_r       <= black ? '0 : in_red;
      out_green_r     <= black ? '0 : in_green;
      out_blue_r      <= black ? '0 : in_blue;
      out_blackened_r <= black;
      out_frame_end_r <= pos.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;
  assign out_blackened = out_blackened_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// ----- hw/rtl/gwck_chk.sv -----
// Port-level checks for the grid window color key mask, with bind.
`timescale 1ns / 1ps
module gwck_chk import gwck_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CH_W-1:0]   out_red,
  input logic [CH_W-1:0]   out_green,
  input logic [CH_W-1:0]   out_blue,
  input logic              out_blackened,
  input logic              out_frame_end
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_blackened) && $stable(out_frame_end))
    else $error("result changed while stalled");

  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_blackened |-> out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("blackened pixel has nonzero color");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

endmodule

bind grid_window_color_key_mask gwck_chk u_gwck_chk (.*);

// ----- test/grid_mask_checker.sv -----
// Checker for the grid window color key mask: snoops config, predicts each pixel, compares.
`timescale 1ns / 1ps
module grid_mask_checker import gwck_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CH_W-1:0]   in_red,
  input  logic [CH_W-1:0]   in_green,
  input  logic [CH_W-1:0]   in_blue,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CH_W-1:0]   out_red,
  input  logic [CH_W-1:0]   out_green,
  input  logic [CH_W-1:0]   out_blue,
  input  logic              out_blackened,
  input  logic              out_frame_end,
  output int                mismatches,
  output int                pending_results,
  output int                results_checked,
  output int                blackened_seen,
  output int                frames_seen
);

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            blackened;
    logic            frame_end;
  } masked_pixel_t;

  masked_pixel_t expected_pixels[$];
  cfg_t          regs;

  logic [COORD_BITS_DEF-1:0] pix_col, pix_row;
  logic [GCOL_W-1:0]         blk_col;
  logic [OFF_W-1:0]          col_off;
  logic [GROW_W-1:0]         blk_row;
  logic [OFF_W-1:0]          row_off;

  // Every block covering the pixel along one axis must hold it in its window.
  function automatic logic axis_holds(input int idx, input int off, input int count,
                                      input int pitch, input int blk, input int half,
                                      input logic row_shift, output logic covered);
    int   half_blk;
    int   delta;
    logic ok;
    half_blk = blk / 2;
    ok = 1'b1;
    covered = 1'b0;
    if (idx < count) begin
      covered = 1'b1;
      delta = off - half_blk - (row_shift ? idx : 0);
      if (delta < -half || delta > half) ok = 1'b0;
    end
    // shared edge: also the far edge of the previous block
    if (off == 0 && idx > 0 && idx <= count) begin
      covered = 1'b1;
      delta = pitch - half_blk - (row_shift ? idx - 1 : 0);
      if (delta < -half || delta > half) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic is_strong(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                     input logic [CH_W-1:0] b);
    logic r_dom, g_dom, b_dom, r_low, g_low, b_low;
    r_dom = 255 - int'(r) <= int'(regs.strong_tolerance);
    g_dom = 255 - int'(g) <= int'(regs.green_strong_tolerance);
    b_dom = 255 - int'(b) <= int'(regs.strong_tolerance);
    r_low = int'(r) <= 110;
    g_low = int'(g) <= 110;
    b_low = int'(b) <= 110;
    return (r_dom && g_low && b_low) || (r_low && g_dom && b_low) || (r_low && g_low && b_dom);
  endfunction

  function automatic masked_pixel_t mask_next_pixel(input logic [CH_W-1:0] r,
                                                    input logic [CH_W-1:0] g,
                                                    input logic [CH_W-1:0] b);
    int            pitch_x, pitch_y;
    logic          x_cov, y_cov, x_ok, y_ok, black, row_end, last_px;
    masked_pixel_t res;
    pitch_x = int'(regs.tile_width) + SEPARATOR_DEF;
    pitch_y = int'(regs.tile_height) + SEPARATOR_DEF;
    x_ok = axis_holds(blk_col, col_off, GRID_COLUMNS_DEF, pitch_x, regs.tile_width,
                      regs.half_window_width, 1'b0, x_cov);
    y_ok = axis_holds(blk_row, row_off, GRID_ROWS_DEF, pitch_y, regs.tile_height,
                      regs.half_window_height, 1'b1, y_cov);
    black = x_cov && y_cov && (!(x_ok && y_ok) || is_strong(r, g, b));
    row_end = int'(pix_col) + 1 >= int'(regs.image_width);
    last_px = row_end && (int'(pix_row) + 1 >= int'(regs.image_height));
    res.red = black ? '0 : r;
    res.green = black ? '0 : g;
    res.blue = black ? '0 : b;
    res.blackened = black;
    res.frame_end = last_px;
    if (row_end) begin
      pix_col = '0;
      blk_col = '0;
      col_off = '0;
      if (last_px) begin
        pix_row = '0;
        blk_row = '0;
        row_off = '0;
      end else begin
        pix_row = pix_row + 1'b1;
        if (blk_row < GRID_ROWS_DEF && int'(row_off) + 1 >= pitch_y) begin
          blk_row = blk_row + 1'b1;
          row_off = '0;
        end else begin
          row_off = row_off + 1'b1;
        end
      end
    end else begin
      pix_col = pix_col + 1'b1;
      if (blk_col < GRID_COLUMNS_DEF && int'(col_off) + 1 >= pitch_x) begin
        blk_col = blk_col + 1'b1;
        col_off = '0;
      end else begin
        col_off = col_off + 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d want %0d", results_checked, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    masked_pixel_t want;
    if (!rst_n) begin
      regs.image_width = IMAGE_WIDTH_RST;
      regs.image_height = IMAGE_HEIGHT_RST;
      regs.tile_width = TILE_WIDTH_RST;
      regs.tile_height = TILE_HEIGHT_RST;
      regs.half_window_width = HALF_WIN_W_RST;
      regs.half_window_height = HALF_WIN_H_RST;
      regs.strong_tolerance = STRONG_TOL_RST;
      regs.green_strong_tolerance = GREEN_TOL_RST;
      pix_col = '0;
      pix_row = '0;
      blk_col = '0;
      col_off = '0;
      blk_row = '0;
      row_off = '0;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_IMAGE_WIDTH:        regs.image_width = pwdata[IMG_W-1:0];
          REG_IMAGE_HEIGHT:       regs.image_height = pwdata[IMG_W-1:0];
          REG_TILE_WIDTH:         regs.tile_width = pwdata[BLK_W-1:0];
          REG_TILE_HEIGHT:        regs.tile_height = pwdata[BLK_W-1:0];
          REG_HALF_WINDOW_WIDTH:  regs.half_window_width = pwdata[BLK_W-1:0];
          REG_HALF_WINDOW_HEIGHT: regs.half_window_height = pwdata[BLK_W-1:0];
          REG_STRONG_TOL:         regs.strong_tolerance = pwdata[TOL_W-1:0];
          REG_GREEN_STRONG_TOL:   regs.green_strong_tolerance = pwdata[TOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(mask_next_pixel(in_red, in_green, in_blue));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with no request pending", 1, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_red !== want.red) report_mismatch("out_red", out_red, want.red);
          if (out_green !== want.green) report_mismatch("out_green", out_green, want.green);
          if (out_blue !== want.blue) report_mismatch("out_blue", out_blue, want.blue);
          if (out_blackened !== want.blackened)
            report_mismatch("out_blackened", out_blackened, want.blackened);
          if (out_frame_end !== want.frame_end)
            report_mismatch("out_frame_end", out_frame_end, want.frame_end);
          if (want.blackened) blackened_seen++;
          if (want.frame_end) frames_seen++;
          results_checked++;
        end
      end
    end
    pending_results = expected_pixels.size();
  end

endmodule

// ----- test/tb_grid_window_color_key_mask.sv -----
// Testbench top for the grid window color key mask: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module tb_grid_window_color_key_mask;
  import gwck_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 650;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CH_W-1:0]   in_red = '0;
  logic [CH_W-1:0]   in_green = '0;
  logic [CH_W-1:0]   in_blue = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CH_W-1:0]   out_red, out_green, out_blue;
  logic              out_blackened, out_frame_end;

  int mismatches, pending_results, results_checked, blackened_seen, frames_seen;
  int settings_used = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int rx_mode = 0;
  int mode_age = 0;

  logic [23:0] directed_pixels [0:20] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hEB6E6E, 24'hEA6E6E,
    24'hEB6F6E, 24'h6EAF6E, 24'h6EAE6E, 24'h6E6EEB, 24'h6E6EEA, 24'hFFFF00, 24'h00FFFF,
    24'hFF00FF, 24'h808080, 24'h010204, 24'h081020, 24'h408000, 24'hAA55AA, 24'h55AA55
  };

  grid_window_color_key_mask dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_blackened(out_blackened), .out_frame_end(out_frame_end)
  );

  grid_mask_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_blackened(out_blackened), .out_frame_end(out_frame_end),
    .mismatches(mismatches), .pending_results(pending_results),
    .results_checked(results_checked), .blackened_seen(blackened_seen),
    .frames_seen(frames_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver: always ready, sparse random stalls, or runs of stalls
  always @(posedge clk) begin
    if (mode_age == 0) begin
      rx_mode = $urandom_range(0, 2);
      mode_age = $urandom_range(20, 150);
    end
    mode_age = mode_age - 1;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_for_results();
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_mask_config(input int img_w, input int img_h, input int blk_w,
                                  input int blk_h, input int half_w, input int half_h,
                                  input int tol, input int green_tol);
    wait_for_results();
    repeat (2) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, img_w);
    write_reg(REG_IMAGE_HEIGHT, img_h);
    write_reg(REG_TILE_WIDTH, blk_w);
    write_reg(REG_TILE_HEIGHT, blk_h);
    write_reg(REG_HALF_WINDOW_WIDTH, half_w);
    write_reg(REG_HALF_WINDOW_HEIGHT, half_h);
    write_reg(REG_STRONG_TOL, tol);
    write_reg(REG_GREEN_STRONG_TOL, green_tol);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic push_pixel(input logic [23:0] rgb);
    in_valid <= 1'b1;
    in_red <= rgb[23:16];
    in_green <= rgb[15:8];
    in_blue <= rgb[7:0];
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly near-strong colors so the tolerance edges get hit
  function automatic logic [23:0] random_colour();
    int          dom;
    int          i;
    logic [7:0]  ch [0:2];
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    dom = $urandom_range(0, 2);
    for (i = 0; i < 3; i++)
      ch[i] = (i == dom) ? 8'(255 - $urandom_range(0, 100)) : 8'($urandom_range(0, 140));
    return {ch[0], ch[1], ch[2]};
  endfunction

  task automatic stream_pixels(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) push_pixel(random_colour());
      left -= burst;
      if ($urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        wait_for_results();
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int i;
    int phase;
    int count;
    int sent_random;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a few pixels at reset settings, then a fully covered grid for the color tests
    for (i = 0; i < 4; i++) push_pixel(directed_pixels[i]);
    in_valid <= 1'b0;
    load_mask_config(4, 3, 1, 1, 4095, 4095, 20, 80);
    for (i = 0; i < 21; i++) push_pixel(directed_pixels[i]);
    in_valid <= 1'b0;

    sent_random = 0;
    phase = 0;
    while (sent_random < RANDOM_ITEMS) begin
      if (phase == 0) begin
        load_mask_config(1, 4096, 4095, 4095, 0, 0, 0, 0);
        count = 40;
      end else if (phase == 1) begin
        load_mask_config(4096, 1, 1, 1, 4095, 4095, 255, 255);
        count = 40;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            // wide rows, past the last grid column
            load_mask_config($urandom_range(40, 90), $urandom_range(2, 8),
                             $urandom_range(1, 3), $urandom_range(1, 3),
                             $urandom_range(0, 2), $urandom_range(0, 3),
                             $urandom_range(0, 255), $urandom_range(0, 255));
            count = $urandom_range(60, 120);
          end
          1: begin
            // narrow rows, down past the last grid row
            load_mask_config($urandom_range(1, 4), $urandom_range(20, 60),
                             $urandom_range(1, 4), $urandom_range(1, 3),
                             $urandom_range(0, 3), $urandom_range(0, 6),
                             $urandom_range(0, 255), $urandom_range(0, 255));
            count = $urandom_range(60, 120);
          end
          default: begin
            load_mask_config($urandom_range(1, 30), $urandom_range(1, 20),
                             $urandom_range(1, 12), $urandom_range(1, 12),
                             $urandom_range(0, 8), $urandom_range(0, 10),
                             $urandom_range(0, 255), $urandom_range(0, 255));
            count = $urandom_range(20, 60);
          end
        endcase
      end
      if (count > RANDOM_ITEMS - sent_random) count = RANDOM_ITEMS - sent_random;
      stream_pixels(count);
      sent_random += count;
      phase++;
    end

    wait_for_results();
    repeat (3) @(posedge clk);
    $display("Checked %0d pixels under %0d register settings, range extremes included.",
             results_checked, settings_used);
    $display("%0d pixels came out blackened and %0d frame ends were seen.",
             blackened_seen, frames_seen);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
